// ===== design/bms_pkg.sv =====
// Package for the bundle message splitter: phase codes, result record and
// queue sizing. No dependencies; imported by the parser, queue and top level.
package bms_pkg;

  // Largest payload in bytes; bytes_after values at or above it are clamped
  localparam int MAX_PAYLOAD = 16384;
  localparam logic [16:0] AFTER_MAX = 17'(MAX_PAYLOAD - 1);

  // Bundle marker and length escape
  localparam logic [7:0] BUNDLE_B0  = 8'h00;
  localparam logic [7:0] BUNDLE_B1  = 8'h19;
  localparam logic [7:0] LEN_ESCAPE = 8'hFF;

  // Parser phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HELD       = 3'd1;
  localparam logic [2:0] PH_PLAIN      = 3'd2;
  localparam logic [2:0] PH_LEN        = 3'd3;
  localparam logic [2:0] PH_LENHI      = 3'd4;
  localparam logic [2:0] PH_LENLO      = 3'd5;
  localparam logic [2:0] PH_BODY_FIRST = 3'd6;
  localparam logic [2:0] PH_BODY       = 3'd7;

  // Result queue: room for two in-flight items of two results each
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam logic [QCNT_W-1:0] READY_LEVEL = QCNT_W'(QDEPTH - 4);

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       msg_first;
    logic       msg_last;
    logic       packet_error;
    logic       run_last;
  } res_t;

  // Up to two results pushed into the queue in one cycle, first in r0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ===== design/bms_parser.sv =====
// Parser stage: input register, bundle/length state machine, and the
// up to two results each byte gives. Depends on bms_pkg.
module bms_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_take,
  input  logic [7:0]     data_byte,
  input  logic           packet_start,
  input  logic [13:0]    bytes_after,
  input  logic           empty_packet,
  output bms_pkg::push_t push
);
  import bms_pkg::*;

  // Input register
  logic        item_valid;
  logic [7:0]  b;
  logic        start;
  logic [13:0] after_raw;
  logic        empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      b         <= data_byte;
      start     <= packet_start;
      after_raw <= bytes_after;
      empty     <= empty_packet;
    end
  end

  // Parser state
  logic [2:0]  phase, phase_next;
  logic [7:0]  held_first_byte, held_first_byte_next;
  logic [7:0]  length_high_byte, length_high_byte_next;
  logic [15:0] body_bytes_left, body_bytes_left_next;

  logic [13:0] after;
  logic        after_zero;
  logic [15:0] len;
  logic        done;
  logic        cut;

  // Clamp of the remaining count to the payload limit
  always_comb begin
    if (17'(after_raw) > AFTER_MAX) begin
      after = AFTER_MAX[13:0];
    end else begin
      after = after_raw;
    end
  end

  assign after_zero = (after == 14'd0);
  assign len  = (phase == PH_LENLO) ? {length_high_byte, b} : {8'd0, b};
  assign done = (body_bytes_left <= 16'd1);
  assign cut  = !done && after_zero;

  // Next state and results
  always_comb begin
    phase_next            = phase;
    held_first_byte_next  = held_first_byte;
    length_high_byte_next = length_high_byte;
    body_bytes_left_next  = body_bytes_left;
    push                  = '0;

    if (item_valid) begin
      if (empty) begin
        push.v0              = 1'b1;
        push.r0.msg_first    = 1'b1;
        push.r0.msg_last     = 1'b1;
        phase_next           = PH_IDLE;
      end else if (start) begin
        if (after_zero) begin
          push.v0            = 1'b1;
          push.r0.out_byte   = b;
          push.r0.has_byte   = 1'b1;
          push.r0.msg_first  = 1'b1;
          push.r0.msg_last   = 1'b1;
          phase_next         = PH_IDLE;
        end else begin
          held_first_byte_next = b;
          phase_next           = PH_HELD;
        end
      end else begin
        case (phase)
          PH_HELD: begin
            if (held_first_byte == BUNDLE_B0 && b == BUNDLE_B1) begin
              phase_next = after_zero ? PH_IDLE : PH_LEN;
            end else begin
              push.v0            = 1'b1;
              push.r0.out_byte   = held_first_byte;
              push.r0.has_byte   = 1'b1;
              push.r0.msg_first  = 1'b1;
              push.v1            = 1'b1;
              push.r1.out_byte   = b;
              push.r1.has_byte   = 1'b1;
              push.r1.msg_last   = after_zero;
              phase_next         = after_zero ? PH_IDLE : PH_PLAIN;
            end
          end
          PH_PLAIN: begin
            push.v0          = 1'b1;
            push.r0.out_byte = b;
            push.r0.has_byte = 1'b1;
            push.r0.msg_last = after_zero;
            if (after_zero) begin
              phase_next = PH_IDLE;
            end
          end
          PH_LEN, PH_LENLO: begin
            if (phase == PH_LEN && b == LEN_ESCAPE) begin
              if (after < 14'd2) begin
                push.v0              = 1'b1;
                push.r0.packet_error = 1'b1;
                phase_next           = PH_IDLE;
              end else begin
                phase_next = PH_LENHI;
              end
            end else if (len == 16'd0) begin
              // zero length: one empty message
              push.v0           = 1'b1;
              push.r0.msg_first = 1'b1;
              push.r0.msg_last  = 1'b1;
              phase_next        = after_zero ? PH_IDLE : PH_LEN;
            end else if (len > 16'(after)) begin
              // too long for what is left: drop the rest
              phase_next = PH_IDLE;
            end else begin
              body_bytes_left_next = len;
              phase_next           = PH_BODY_FIRST;
            end
          end
          PH_LENHI: begin
            if (after_zero) begin
              push.v0              = 1'b1;
              push.r0.packet_error = 1'b1;
              phase_next           = PH_IDLE;
            end else begin
              length_high_byte_next = b;
              phase_next            = PH_LENLO;
            end
          end
          PH_BODY_FIRST, PH_BODY: begin
            push.v0              = 1'b1;
            push.r0.out_byte     = b;
            push.r0.has_byte     = 1'b1;
            push.r0.msg_first    = (phase == PH_BODY_FIRST);
            push.r0.msg_last     = done || cut;
            push.r0.packet_error = cut;
            if (body_bytes_left != 16'd0) begin
              body_bytes_left_next = body_bytes_left - 16'd1;
            end
            if (after_zero) begin
              phase_next = PH_IDLE;
            end else if (done) begin
              phase_next = PH_LEN;
            end else begin
              phase_next = PH_BODY;
            end
          end
          default: begin
            // idle: bytes outside a packet are ignored
          end
        endcase
      end
    end

    // Mark the last result of this transaction
    if (push.v1) begin
      push.r1.run_last = 1'b1;
    end else if (push.v0) begin
      push.r0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      held_first_byte  <= 8'd0;
      length_high_byte <= 8'd0;
      body_bytes_left  <= 16'd0;
    end else begin
      phase            <= phase_next;
      held_first_byte  <= held_first_byte_next;
      length_high_byte <= length_high_byte_next;
      body_bytes_left  <= body_bytes_left_next;
    end
  end

endmodule

// ===== design/bms_queue.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle on the
// stream output while it is popped. Depends on bms_pkg.
module bms_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  bms_pkg::push_t             push,
  input  logic                       pop,
  output logic                       not_empty,
  output bms_pkg::res_t              head,
  output logic [bms_pkg::QCNT_W-1:0] level
);
  import bms_pkg::*;

  res_t               mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QPTR_W-1:0]  wr_ptr1;
  logic [1:0]         n_wr;

  assign wr_ptr1   = wr_ptr + QPTR_W'(1);
  assign n_wr      = {1'b0, push.v0} + {1'b0, push.v1};
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];
  assign level     = count;

  // Storage writes, first result at the write pointer
  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(n_wr);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(n_wr) - QCNT_W'(pop);
    end
  end

endmodule

// ===== design/bundle_message_splitter_top.sv =====
// Bundle message splitter, top level: stream ports, parser and result queue.
// Depends on bms_pkg, bms_parser and bms_queue.
//
// Usage: payload bytes of a decrypted packet enter on the s_axis channel,
// one byte per transaction, with packet_start and empty_packet in tuser and
// the count of bytes still to follow in tdata. Messages leave on m_axis, one
// result per transaction: the byte in tdata, its marks in tuser, and tlast
// on the last result that an input byte causes. A bundle (payload opening
// with 0x00 0x19) is cut into its length-prefixed sub-messages.
// The results of a byte pass through the input register and the result queue
// before they are offered on m_axis; a second result follows once the first is taken.
// Throughput: one byte per cycle while tready is high; a non-bundle payload gives
// two results on its second byte, which the eight-entry result queue absorbs.
// s_axis_tready depends only on reset and the queue level, so while m_axis is
// stalled the block keeps taking bytes as long as the queue holds four results
// or fewer, then holds tready low; nothing is lost.
// Reset clears the parser to idle and empties the queue; tready is low in reset.
module bundle_message_splitter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [21:8] bytes_after, zero pad
  input  logic [1:0]  s_axis_tuser,  // [0] packet_start, [1] empty_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [3:0]  m_axis_tuser,  // [0] has_byte, [1] msg_first, [2] msg_last,
                                     // [3] packet_error
  output logic        m_axis_tlast   // run_last
);
  import bms_pkg::*;

  push_t             push;
  res_t              head;
  logic [QCNT_W-1:0] level;
  logic              in_take;
  logic              pop;

  // Accept while the queue has room for this and the pending item
  assign s_axis_tready = !rst && (level <= READY_LEVEL);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;

  bms_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_take      (in_take),
    .data_byte    (s_axis_tdata[7:0]),
    .packet_start (s_axis_tuser[0]),
    .bytes_after  (s_axis_tdata[21:8]),
    .empty_packet (s_axis_tuser[1]),
    .push         (push)
  );

  bms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .not_empty (m_axis_tvalid),
    .head      (head),
    .level     (level)
  );

  // Output packing
  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.packet_error, head.msg_last, head.msg_first, head.has_byte};
  assign m_axis_tlast = head.run_last;

endmodule

// ===== design/bms_checker.sv =====
// Port-level checks for the bundle message splitter, bound to the top level.
// Depends only on the top level's ports.
module bms_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A result without a byte carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
    else $error("byte field not zero on an empty result");

  // Byteless results are either an empty message or a bare error status
  a_byteless_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      (m_axis_tuser[1] && m_axis_tuser[2] && !m_axis_tuser[3] && m_axis_tlast)
      || (!m_axis_tuser[1] && !m_axis_tuser[2] && m_axis_tuser[3] && m_axis_tlast))
    else $error("malformed byteless result");

endmodule

bind bundle_message_splitter_top bms_checker u_bms_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
